FILE: hw/rtl/qssg_pkg.sv
package qssg_pkg;

	// Fixed widths of the stream fields and the configuration register.
	localparam int HGT_W  = 16;
	localparam int VAL_W  = 40;
	localparam int FRAC_W = 16;
	localparam int CFG_W  = 7;
	localparam int DEF_MAX_POINTS = 64;

	localparam logic [CFG_W-1:0] CFG_RESET = 7'd8;

	// Saturation limits of the signed Q24.16 value range.
	localparam logic signed [VAL_W-1:0] V_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] V_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	// Command code carried in tuser.
	localparam logic CMD_QUAD = 1'b0;
	localparam logic CMD_LIN  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DSTART,
		ST_DWAIT,
		ST_COEF,
		ST_RUN,
		ST_SLOPE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic num;
		logic div_start;
		logic coef;
		logic emit;
		logic slope;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_done;
		logic last;
		logic out_free;
	} status_t;

endpackage

FILE: hw/rtl/quadratic_spline_segment_gen_top.sv
// After the input transfer the controller forms the numerator, starts the two-bit-per-cycle divider,
// waits for its quotient and sets up the coefficients before the first sample is emitted.
// Throughput: one sample per cycle while the output is not stalled by m_tready; one segment
// is in flight at a time.
// Reset: arst_n is asynchronous and active low; it sets points_per_segment to 8, clears the
// carried slope and empties the output register.
module quadratic_spline_segment_gen_top #(
	parameter int MAX_POINTS = qssg_pkg::DEF_MAX_POINTS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// Configuration: points_per_segment, written when cfg_wen is high.
	input  logic                         cfg_wen,
	input  logic [qssg_pkg::CFG_W-1:0]   cfg_wdata,
	// Segment input stream.
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// tdata fields from bit 0 up: start_height [15:0], end_height [31:16].
	input  logic [2*qssg_pkg::HGT_W-1:0] s_tdata,
	// tuser fields from bit 0 up: cmd (0 quadratic, 1 linear).
	input  logic                         s_tuser,
	// Sample output stream.
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// tdata fields from bit 0 up: sample_value [39:0], signed Q24.16.
	output logic [qssg_pkg::VAL_W-1:0]   m_tdata,
	// tlast marks the final sample of each segment.
	output logic                         m_tlast
);
	import qssg_pkg::*;

	// The controller steps through capture, numerator, divide, coefficient setup,
	// sample emission and slope update. The datapath holds all arithmetic.
	cmd_t    cmd;
	status_t status;

	qssg_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.cmd     (cmd),
		.status  (status)
	);

	// Samples are produced by forward differences: the value accumulator adds
	// the first difference for each emitted sample and the first difference adds twice the
	// quadratic coefficient, so every sample is exact before saturation. The
	// first difference left after the last sample, less the quadratic
	// coefficient, is the new carried slope 2*a*n + b. A result transfer waits
	// in the output register while the next sample is already prepared.
	qssg_dp #(
		.MAX_POINTS(MAX_POINTS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cmd      (cmd),
		.status   (status)
	);

endmodule

FILE: hw/rtl/qssg_div.sv
module qssg_div #(
	parameter int QW = 48,
	parameter int DW = 14
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [QW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [QW-1:0] quo
);

	// Two restoring steps per cycle, so the numerator width is even.
	localparam int ITER = QW / 2;
	localparam int CW   = $clog2(ITER + 1);

	logic [DW-1:0] rem_q;
	logic [QW-1:0] quo_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [DW:0]   r1, r2;
	logic [DW-1:0] rem1, rem2;
	logic [QW-1:0] q1, q2;

	always_comb begin
		r1 = {rem_q, quo_q[QW-1]};
		q1 = {quo_q[QW-2:0], 1'b0};
		if (r1 >= {1'b0, den_q}) begin
			rem1  = DW'(r1 - {1'b0, den_q});
			q1[0] = 1'b1;
		end else begin
			rem1 = DW'(r1);
		end
		r2 = {rem1, q1[QW-1]};
		q2 = {q1[QW-2:0], 1'b0};
		if (r2 >= {1'b0, den_q}) begin
			rem2  = DW'(r2 - {1'b0, den_q});
			q2[0] = 1'b1;
		end else begin
			rem2 = DW'(r2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(ITER);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= rem2;
			quo_q <= q2;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

FILE: hw/rtl/qssg_ctrl.sv
module qssg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output qssg_pkg::cmd_t    cmd,
	input  qssg_pkg::status_t status
);
	import qssg_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.num = 1'b1;
				state_d = ST_DSTART;
			end
			ST_DSTART: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DWAIT;
			end
			ST_DWAIT: begin
				if (status.div_done) begin
					state_d = ST_COEF;
				end
			end
			ST_COEF: begin
				cmd.coef = 1'b1;
				state_d  = ST_RUN;
			end
			ST_RUN: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					if (status.last) begin
						state_d = ST_SLOPE;
					end
				end
			end
			ST_SLOPE: begin
				cmd.slope = 1'b1;
				state_d   = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: hw/rtl/qssg_dp.sv
module qssg_dp #(
	parameter int MAX_POINTS = qssg_pkg::DEF_MAX_POINTS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wen,
	input  logic [qssg_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                         s_tuser,
	input  logic [2*qssg_pkg::HGT_W-1:0] s_tdata,
	input  logic                         m_tready,
	output logic                         m_tvalid,
	output logic [qssg_pkg::VAL_W-1:0]   m_tdata,
	output logic                         m_tlast,
	input  qssg_pkg::cmd_t               cmd,
	output qssg_pkg::status_t            status
);
	import qssg_pkg::*;

	localparam int IW = $clog2(MAX_POINTS + 1);
	localparam int NW = VAL_W + IW + 1;
	localparam int QW = 2 * ((NW + 1) / 2);
	localparam int DW = 2 * IW;
	localparam int AW = VAL_W + 1 + 2 * IW;
	localparam int DIFF_W = HGT_W + 1 + FRAC_W;

	localparam logic signed [QW:0]   QMAX = (QW + 1)'(V_MAX);
	localparam logic signed [QW:0]   QMIN = (QW + 1)'(V_MIN);
	localparam logic signed [AW-1:0] AMAX = AW'(V_MAX);
	localparam logic signed [AW-1:0] AMIN = AW'(V_MIN);

	function automatic logic signed [VAL_W-1:0] sat_quo(input logic signed [QW:0] x);
		if (x > QMAX) begin
			return V_MAX;
		end else if (x < QMIN) begin
			return V_MIN;
		end
		return VAL_W'(x);
	endfunction

	function automatic logic signed [VAL_W-1:0] sat_acc(input logic signed [AW-1:0] x);
		if (x > AMAX) begin
			return V_MAX;
		end else if (x < AMIN) begin
			return V_MIN;
		end
		return VAL_W'(x);
	endfunction

	logic [CFG_W-1:0]         points_q;
	logic                     lin_q;
	logic signed [HGT_W-1:0]  start_q, end_q;
	logic [IW-1:0]            n_q, n_clamp, cnt_q;
	logic signed [VAL_W-1:0]  slope_q, qa_q;
	logic signed [NW-1:0]     num_q;
	logic [DW-1:0]            den_q;
	logic                     neg_q;
	logic signed [AW-1:0]     v_q, d_q;
	logic                     out_valid_q;
	logic [VAL_W-1:0]         out_data_q;
	logic                     out_last_q;

	logic signed [HGT_W:0]    diff_int;
	logic signed [DIFF_W-1:0] diff;
	logic signed [NW-1:0]     slope_x, n_x, nb;
	logic [NW-1:0]            mag;
	logic [QW-1:0]            quo;
	logic                     div_done;
	logic signed [QW:0]       quo_s;
	logic signed [VAL_W-1:0]  a_sat, qa_new, lb_new;
	logic signed [AW-1:0]     base_x;

	// Effective segment length: zero reads as one, the top is clamped.
	always_comb begin
		if (points_q == '0) begin
			n_clamp = IW'(1);
		end else if (32'(points_q) > MAX_POINTS) begin
			n_clamp = IW'(MAX_POINTS);
		end else begin
			n_clamp = IW'(points_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_q    <= CFG_RESET;
			slope_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				points_q <= cfg_wdata;
			end
			if (cmd.slope) begin
				slope_q <= sat_acc(d_q - AW'(qa_q));
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign diff_int = $signed({end_q[HGT_W-1], end_q}) - $signed({start_q[HGT_W-1], start_q});
	assign diff     = {diff_int, {FRAC_W{1'b0}}};
	assign slope_x  = NW'(slope_q);
	assign n_x      = $signed({{(NW - IW){1'b0}}, n_q});
	assign nb       = slope_x * n_x;
	assign mag      = num_q[NW-1] ? NW'(-num_q) : NW'(num_q);

	qssg_div #(
		.QW(QW),
		.DW(DW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (QW'(mag)),
		.den   (den_q),
		.done  (div_done),
		.quo   (quo)
	);

	assign quo_s  = neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
	assign a_sat  = sat_quo(quo_s);
	assign qa_new = lin_q ? '0 : a_sat;
	assign lb_new = lin_q ? a_sat : slope_q;
	assign base_x = AW'($signed({start_q, {FRAC_W{1'b0}}}));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lin_q   <= (s_tuser == CMD_LIN);
			start_q <= s_tdata[HGT_W-1:0];
			end_q   <= s_tdata[2*HGT_W-1:HGT_W];
			n_q     <= n_clamp;
		end
		if (cmd.num) begin
			if (lin_q) begin
				num_q <= NW'(diff);
				den_q <= DW'(n_q);
			end else begin
				num_q <= NW'(diff) - nb;
				den_q <= DW'(n_q) * DW'(n_q);
			end
		end
		if (cmd.div_start) begin
			neg_q <= num_q[NW-1];
		end
		if (cmd.coef) begin
			qa_q  <= qa_new;
			v_q   <= base_x;
			d_q   <= AW'(qa_new) + AW'(lb_new);
			cnt_q <= '0;
		end
		if (cmd.emit) begin
			out_data_q <= sat_acc(v_q);
			out_last_q <= status.last;
			v_q        <= v_q + d_q;
			d_q        <= d_q + (AW'(qa_q) <<< 1);
			cnt_q      <= cnt_q + IW'(1);
		end
	end

	assign status.div_done = div_done;
	assign status.last     = (cnt_q == n_q - IW'(1));
	assign status.out_free = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule
